/* hw/rtl/tkd_pkg.sv */
// shared types, constants and helper functions of the terminal key sequence decoder
// no dependencies; imported by every module of the block

package tkd_pkg;

  localparam int MAX_PARAMS = 4;
  localparam int PARAM_BITS = 16;
  localparam int PC_W       = $clog2(MAX_PARAMS + 1);
  localparam int CP_W       = 21;

  localparam logic [PARAM_BITS-1:0] PARAM_MAX = {PARAM_BITS{1'b1}};

  // depth of the record queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // byte codes
  localparam logic [7:0] B_ESC   = 8'd27;
  localparam logic [7:0] B_CR    = 8'd13;
  localparam logic [7:0] B_LF    = 8'd10;
  localparam logic [7:0] B_DEL   = 8'd127;
  localparam logic [7:0] B_BS    = 8'd8;
  localparam logic [7:0] B_TAB   = 8'd9;
  localparam logic [7:0] B_LBRK  = 8'h5B;
  localparam logic [7:0] B_LET_O = 8'h4F;
  localparam logic [7:0] B_SEMI  = 8'h3B;
  localparam logic [7:0] B_TILDE = 8'h7E;
  localparam logic [7:0] B_ZERO  = 8'h30;
  localparam logic [7:0] B_NINE  = 8'h39;
  localparam logic [7:0] B_LET_A = 8'h41;
  localparam logic [7:0] B_LET_B = 8'h42;
  localparam logic [7:0] B_LET_C = 8'h43;
  localparam logic [7:0] B_LET_D = 8'h44;
  localparam logic [7:0] B_LET_F = 8'h46;
  localparam logic [7:0] B_LET_H = 8'h48;
  localparam logic [7:0] UTF_3B  = 8'hE0;
  localparam logic [7:0] UTF_4B  = 8'hF0;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_GAP    = 2'd1,
    CMD_RESIZE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_CSI  = 3'd2,
    MODE_SS3  = 3'd3,
    MODE_UTF  = 3'd4
  } mode_e;

  typedef enum logic [4:0] {
    K_CHAR    = 5'd0,
    K_UP      = 5'd1,
    K_DOWN    = 5'd2,
    K_RIGHT   = 5'd3,
    K_LEFT    = 5'd4,
    K_HOME    = 5'd5,
    K_END     = 5'd6,
    K_INS     = 5'd7,
    K_DEL     = 5'd8,
    K_PGUP    = 5'd9,
    K_PGDOWN  = 5'd10,
    K_ESC     = 5'd11,
    K_ENTER   = 5'd12,
    K_BKSP    = 5'd13,
    K_TAB     = 5'd14,
    K_INVALID = 5'd15,
    K_RESIZE  = 5'd16
  } key_e;

  typedef struct packed {
    key_e            kind;
    logic [CP_W-1:0] cp;
    logic            shift;
    logic            alt;
    logic            ctrl;
  } res_t;

  // one record per item: an optional key, then an optional resize
  typedef struct packed {
    logic has_key;
    logic has_resize;
    res_t key;
  } rec_t;

  function automatic key_e arrow_kind(logic [7:0] b);
    key_e k;
    unique case (b)
      B_LET_A: k = K_UP;
      B_LET_B: k = K_DOWN;
      B_LET_C: k = K_RIGHT;
      B_LET_D: k = K_LEFT;
      B_LET_H: k = K_HOME;
      B_LET_F: k = K_END;
      default: k = K_ESC;
    endcase
    return k;
  endfunction

  // p * 10 + d, saturating at the top of the parameter range
  function automatic logic [PARAM_BITS-1:0] sat_digit(logic [PARAM_BITS-1:0] p,
                                                      logic [3:0] d);
    logic [PARAM_BITS+3:0] v;
    v = ({4'd0, p} << 3) + ({4'd0, p} << 1) + {{PARAM_BITS{1'b0}}, d};
    return (v > {4'd0, PARAM_MAX}) ? PARAM_MAX : v[PARAM_BITS-1:0];
  endfunction

endpackage

/* hw/rtl/tkd_front.sv */
// front end: accepts input words, runs the escape / csi / utf-8 parser
// and produces at most one result record per word; uses tkd_pkg

module tkd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [1:0]       cmd_i,
  input  logic [7:0]       byte_i,
  input  logic             full_i,
  output logic             push_o,
  output tkd_pkg::rec_t    rec_o
);
  import tkd_pkg::*;

  mode_e                 mode_q, mode_d;
  logic                  alt_q, alt_d;
  logic [1:0]            rem_q, rem_d;
  logic [CP_W-1:0]       acc_q, acc_d;
  logic [PARAM_BITS-1:0] p1_q, p1_d;
  logic [PARAM_BITS-1:0] p2_q, p2_d;
  logic [PC_W-1:0]       pc_q, pc_d;

  logic                  accept;
  rec_t                  rec;
  logic [PC_W-1:0]       pc_cur;
  logic [PC_W:0]         pc_inc;
  logic [2:0]            modv;
  key_e                  fkind;

  assign ready_o = !full_i;
  assign accept  = valid_i && !full_i;
  assign push_o  = accept && (rec.has_key || rec.has_resize);
  assign rec_o   = rec;

  always_comb begin
    mode_d = mode_q;
    alt_d  = alt_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    p1_d   = p1_q;
    p2_d   = p2_q;
    pc_d   = pc_q;
    rec    = '0;
    pc_cur = (pc_q == '0) ? PC_W'(1) : pc_q;
    pc_inc = (pc_q == '0) ? (PC_W + 1)'(2) : ({1'b0, pc_q} + (PC_W + 1)'(1));
    modv   = p2_q[2:0] - 3'd1;
    fkind  = K_ESC;

    unique case (cmd_e'(cmd_i))
      CMD_BYTE: begin
        unique case (mode_q)
          MODE_IDLE: begin
            if (byte_i == B_ESC) begin
              mode_d = MODE_ESC;
            end else if (byte_i == B_CR || byte_i == B_LF) begin
              rec.has_key  = 1'b1;
              rec.key.kind = K_ENTER;
            end else if (byte_i == B_DEL || byte_i == B_BS) begin
              rec.has_key  = 1'b1;
              rec.key.kind = K_BKSP;
            end else if (byte_i == B_TAB) begin
              rec.has_key  = 1'b1;
              rec.key.kind = K_TAB;
            end else if (byte_i[7]) begin
              mode_d = MODE_UTF;
              alt_d  = 1'b0;
              if (byte_i < UTF_3B) begin
                acc_d = CP_W'(byte_i[4:0]);
                rem_d = 2'd1;
              end else if (byte_i < UTF_4B) begin
                acc_d = CP_W'(byte_i[3:0]);
                rem_d = 2'd2;
              end else begin
                acc_d = CP_W'(byte_i[2:0]);
                rem_d = 2'd3;
              end
            end else begin
              rec.has_key  = 1'b1;
              rec.key.kind = K_CHAR;
              rec.key.cp   = CP_W'(byte_i);
            end
          end
          MODE_ESC: begin
            // fields are already clear while in escape mode
            if (byte_i == B_LBRK) begin
              mode_d = MODE_CSI;
            end else if (byte_i == B_LET_O) begin
              mode_d = MODE_SS3;
            end else if (byte_i[7]) begin
              mode_d = MODE_UTF;
              alt_d  = 1'b1;
              if (byte_i < UTF_3B) begin
                acc_d = CP_W'(byte_i[4:0]);
                rem_d = 2'd1;
              end else if (byte_i < UTF_4B) begin
                acc_d = CP_W'(byte_i[3:0]);
                rem_d = 2'd2;
              end else begin
                acc_d = CP_W'(byte_i[2:0]);
                rem_d = 2'd3;
              end
            end else begin
              rec.has_key  = 1'b1;
              rec.key.kind = K_CHAR;
              rec.key.cp   = CP_W'(byte_i);
              rec.key.alt  = 1'b1;
              mode_d       = MODE_IDLE;
            end
          end
          MODE_CSI: begin
            if (byte_i >= B_ZERO && byte_i <= B_NINE) begin
              pc_d = pc_cur;
              if (pc_cur == PC_W'(1)) begin
                p1_d = sat_digit(p1_q, byte_i[3:0]);
              end else if (pc_cur == PC_W'(2)) begin
                p2_d = sat_digit(p2_q, byte_i[3:0]);
              end
            end else if (byte_i == B_SEMI) begin
              pc_d = (pc_inc > (PC_W + 1)'(MAX_PARAMS)) ? PC_W'(MAX_PARAMS)
                                                         : pc_inc[PC_W-1:0];
            end else begin
              if (byte_i == B_TILDE) begin
                if (p1_q == PARAM_BITS'(2)) begin
                  fkind = K_INS;
                end else if (p1_q == PARAM_BITS'(3)) begin
                  fkind = K_DEL;
                end else if (p1_q == PARAM_BITS'(5)) begin
                  fkind = K_PGUP;
                end else if (p1_q == PARAM_BITS'(6)) begin
                  fkind = K_PGDOWN;
                end else begin
                  fkind = K_ESC;
                end
              end else begin
                fkind = arrow_kind(byte_i);
              end
              rec.has_key  = 1'b1;
              rec.key.kind = fkind;
              if (pc_q >= PC_W'(2)) begin
                rec.key.shift = modv[0];
                rec.key.alt   = modv[1];
                rec.key.ctrl  = modv[2];
              end
              mode_d = MODE_IDLE;
              p1_d   = '0;
              p2_d   = '0;
              pc_d   = '0;
            end
          end
          MODE_SS3: begin
            rec.has_key  = 1'b1;
            rec.key.kind = arrow_kind(byte_i);
            mode_d       = MODE_IDLE;
          end
          MODE_UTF: begin
            if (byte_i[7:6] != 2'b10) begin
              rec.has_key  = 1'b1;
              rec.key.kind = K_INVALID;
              rec.key.alt  = alt_q;
              mode_d = MODE_IDLE;
              alt_d  = 1'b0;
              rem_d  = '0;
              acc_d  = '0;
            end else if (rem_q <= 2'd1) begin
              rec.has_key  = 1'b1;
              rec.key.kind = K_CHAR;
              rec.key.cp   = {acc_q[CP_W-7:0], byte_i[5:0]};
              rec.key.alt  = alt_q;
              mode_d = MODE_IDLE;
              alt_d  = 1'b0;
              rem_d  = '0;
              acc_d  = '0;
            end else begin
              acc_d = {acc_q[CP_W-7:0], byte_i[5:0]};
              rem_d = rem_q - 2'd1;
            end
          end
          default: begin
            mode_d = MODE_IDLE;
            alt_d  = 1'b0;
            rem_d  = '0;
            acc_d  = '0;
            p1_d   = '0;
            p2_d   = '0;
            pc_d   = '0;
          end
        endcase
      end
      CMD_GAP, CMD_RESIZE: begin
        // flush whatever sequence is pending
        if (mode_q == MODE_ESC || mode_q == MODE_CSI || mode_q == MODE_SS3) begin
          rec.has_key  = 1'b1;
          rec.key.kind = K_ESC;
        end else if (mode_q == MODE_UTF) begin
          rec.has_key  = 1'b1;
          rec.key.kind = K_INVALID;
          rec.key.alt  = alt_q;
        end
        rec.has_resize = (cmd_e'(cmd_i) == CMD_RESIZE);
        mode_d = MODE_IDLE;
        alt_d  = 1'b0;
        rem_d  = '0;
        acc_d  = '0;
        p1_d   = '0;
        p2_d   = '0;
        pc_d   = '0;
      end
      default: begin
        // unused command: ignored
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      alt_q  <= 1'b0;
      rem_q  <= '0;
      acc_q  <= '0;
      p1_q   <= '0;
      p2_q   <= '0;
      pc_q   <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      alt_q  <= alt_d;
      rem_q  <= rem_d;
      acc_q  <= acc_d;
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      pc_q   <= pc_d;
    end
  end

endmodule

/* hw/rtl/tkd_queue.sv */
// short record queue between parser front end and output back end
// uses tkd_pkg for the record type and depth

module tkd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tkd_pkg::rec_t push_rec_i,
  output logic          full_o,
  input  logic          pop_i,
  output tkd_pkg::rec_t pop_rec_o,
  output logic          empty_o
);
  import tkd_pkg::*;

  rec_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o    = (cnt_q == (QPTR_W + 1)'(QDEPTH));
  assign empty_o   = (cnt_q == '0);
  assign pop_rec_o = slot_q[rd_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (QPTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_rec_i;
    end
  end

endmodule

/* hw/rtl/tkd_back.sv */
// back end: unpacks queued records into result words on a registered output
// uses tkd_pkg for the record and result types

module tkd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tkd_pkg::rec_t rec_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          valid_o,
  input  logic          ready_i,
  output tkd_pkg::res_t res_o,
  output logic          last_o
);
  import tkd_pkg::*;

  logic valid_q, valid_d;
  logic pend_q, pend_d;
  res_t res_q, res_d;
  logic last_q, last_d;
  logic load;
  res_t resize_res;

  assign valid_o = valid_q;
  assign res_o   = res_q;
  assign last_o  = last_q;

  assign load  = !valid_q || ready_i;
  assign pop_o = load && !pend_q && !empty_i;

  always_comb begin
    resize_res      = '0;
    resize_res.kind = K_RESIZE;
    valid_d = valid_q;
    pend_d  = pend_q;
    res_d   = res_q;
    last_d  = last_q;
    if (load) begin
      if (pend_q) begin
        valid_d = 1'b1;
        res_d   = resize_res;
        last_d  = 1'b1;
        pend_d  = 1'b0;
      end else if (!empty_i) begin
        valid_d = 1'b1;
        if (rec_i.has_key) begin
          res_d  = rec_i.key;
          last_d = !rec_i.has_resize;
          pend_d = rec_i.has_resize;
        end else begin
          res_d  = resize_res;
          last_d = 1'b1;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    last_q <= last_d;
  end

endmodule

/* hw/rtl/terminal_key_sequence_decoder.sv */
// top level of the terminal key sequence decoder
// instantiates tkd_front, tkd_queue and tkd_back; uses tkd_pkg

// Decodes terminal input words into keys. Each input word carries a command in
// s_axis_tuser (byte received, inter-byte gap timeout, window resize) and the byte
// in s_axis_tdata. Recognised are plain characters, enter, backspace, tab, a bare
// esc, esc-prefixed alt keys, csi sequences with up to four decimal parameters
// (xterm modifier from the second one), tilde keys, ss3 arrows and 2- to 4-byte
// utf-8. A gap or resize ends a pending sequence with esc or invalid, and a resize
// then gives a resize key. Each input word gives zero, one or two result words;
// tlast marks the final one of a word. One input word is taken every cycle while
// the four-entry record queue has room; a result passes the queue slot, then the
// back end's output register, and the output side moves one result word a cycle
// while m_axis_tready is high, so words that give two results (a resize during a
// sequence) hold the output longer and back-pressure the input through the queue.

module terminal_key_sequence_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] codepoint, [21] shift, [22] alt, [23] ctrl
  output logic [4:0]  m_axis_tuser,   // [4:0] key_kind
  output logic        m_axis_tlast    // last_of_run
);
  import tkd_pkg::*;

  // front to queue
  logic push;
  rec_t push_rec;
  logic full;

  // queue to back
  logic pop;
  rec_t pop_rec;
  logic empty;

  res_t res;

  // parser: classifies each word and keeps the sequence state
  tkd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .cmd_i   (s_axis_tuser),
    .byte_i  (s_axis_tdata),
    .full_i  (full),
    .push_o  (push),
    .rec_o   (push_rec)
  );

  // decouples the parser from output stalls
  tkd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (full),
    .pop_i      (pop),
    .pop_rec_o  (pop_rec),
    .empty_o    (empty)
  );

  // splits records into one or two result words
  tkd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rec_i   (pop_rec),
    .empty_i (empty),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {res.ctrl, res.alt, res.shift, res.cp};
  assign m_axis_tuser = res.kind;

endmodule
